### sv/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, round constants, initial hash values and sigma functions
// used by the block compressor and its submodules.
// ----------------------------------------------------------------------------
package sha256_pkg;

	localparam int WordW      = 32;
	localparam int HashWords  = 8;
	localparam int BlockWords = 16;
	localparam int RoundCount = 64;

	typedef logic [WordW-1:0] word_t;
	typedef logic [HashWords-1:0][WordW-1:0] hash_t;

	// one incoming message word and its block flags
	typedef struct packed {
		logic [31:0] message_word;
		logic        first_block;
		logic        last_block;
	} msg_t;

	// one outgoing digest word
	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  digest_index;
		logic        digest_last;
	} digest_t;

	// sequencer controls to the schedule window
	typedef struct packed {
		logic shift_in;
		logic step;
	} sched_ctl_t;

	// sequencer controls to the round unit
	typedef struct packed {
		logic load;
		logic step;
	} round_ctl_t;

	function automatic word_t rotr(word_t x, int unsigned n);
		return (x >> n) | (x << (WordW - n));
	endfunction

	function automatic word_t small_s0(word_t x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_s1(word_t x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t big_s0(word_t x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_s1(word_t x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	// standard initial hash values
	function automatic word_t iv_word(logic [2:0] idx);
		word_t r;
		unique case (idx)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			3'd7: r = 32'h5be0cd19;
			default: r = 32'h6a09e667;
		endcase
		return r;
	endfunction

	function automatic hash_t iv_hash();
		hash_t h;
		for (int i = 0; i < HashWords; i++) begin
			h[i] = iv_word(3'(i));
		end
		return h;
	endfunction

	// round constants
	function automatic word_t k_word(logic [5:0] idx);
		word_t r;
		unique case (idx)
			6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
			6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
			6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
			6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
			6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
			6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
			6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
			6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
			6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
			6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
			6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
			6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
			6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
			6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
			6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
			6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
			6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
			6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
			6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
			6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
			6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
			6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
			6'd62: r = 32'hbef9a3f7; 6'd63: r = 32'hc67178f2;
			default: r = 32'h428a2f98;
		endcase
		return r;
	endfunction

endpackage

### sv/sha256_sched.sv
// ----------------------------------------------------------------------------
// SHA-256 message schedule window
// Sixteen-word shift line. Block words shift in one per write; during the
// rounds the oldest word is W(t) and the next schedule word shifts in.
// ----------------------------------------------------------------------------
module sha256_sched
	import sha256_pkg::*;
(
	input  logic       clk,
	input  sched_ctl_t ctl,
	input  word_t      msg_word,
	output word_t      wt
);

	word_t w_q [BlockWords];
	word_t w_next;

	// W(t+16) from the window taps
	always_comb begin
		w_next = small_s1(w_q[14]) + w_q[9] + small_s0(w_q[1]) + w_q[0];
	end

	assign wt = w_q[0];

	// window contents are undefined until the block is loaded
	always_ff @(posedge clk) begin
		if (ctl.shift_in || ctl.step) begin
			for (int i = 0; i < BlockWords - 1; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[BlockWords-1] <= ctl.shift_in ? msg_word : w_next;
		end
	end

endmodule

### sv/sha256_round.sv
// ----------------------------------------------------------------------------
// SHA-256 round unit
// Holds working variables a..h and applies one compression round per step.
// ----------------------------------------------------------------------------
module sha256_round
	import sha256_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  round_ctl_t ctl,
	input  hash_t      init,
	input  word_t      wt,
	input  word_t      kt,
	output hash_t      vars
);

	hash_t v_q;
	word_t t1;
	word_t t2;
	word_t ch;
	word_t maj;

	// round function
	always_comb begin
		ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1  = v_q[7] + big_s1(v_q[4]) + ch + kt + wt;
		t2  = big_s0(v_q[0]) + maj;
	end

	assign vars = v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (ctl.load) begin
			v_q <= init;
		end else if (ctl.step) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

endmodule

### sv/sha256_block_compressor_core.sv
// ----------------------------------------------------------------------------
// SHA-256 block compressor core
// Compresses padded 512-bit blocks, written as sixteen 32-bit words, into
// the chaining hash and emits the eight-word digest after the last block.
// ----------------------------------------------------------------------------
// Usage: write one word per cycle with start while busy is low. Words 0 to
// 14 of a block are taken back to back. The sixteenth word starts the
// compression: busy stays high through the 64 rounds in the single round
// unit and the add into the chaining hash, and through the emit of the
// eight digest words when the block is flagged last. Each digest word
// shows in the cycle after its emit step: they come out one per cycle on
// result with strobe high, word 0 first, and the eighth shows in the first
// cycle with busy low. first_block and last_block are sampled on the
// sixteenth word only. The receiver must take each digest word in the
// cycle strobe is high; there is no hold-off.
// After the digest the chaining hash returns to the initial values.
// ----------------------------------------------------------------------------
module sha256_block_compressor_core
	import sha256_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  msg_t    msg,
	output logic    busy,
	output logic    strobe,
	output digest_t result
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_ROUND,
		S_ADD,
		S_EMIT
	} state_t;

	state_t     state_q;
	logic [5:0] cnt_q;
	logic [3:0] wcnt_q;
	logic       last_q;
	hash_t      h_q;
	logic       strobe_q;
	digest_t    result_q;

	logic       accept;
	logic       blk_done;
	hash_t      h_start;
	hash_t      vars;
	word_t      wt;
	sched_ctl_t sched_ctl;
	round_ctl_t round_ctl;

	// handshake and sequencer controls
	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign blk_done = accept && (wcnt_q == 4'(BlockWords - 1));
	assign h_start  = msg.first_block ? iv_hash() : h_q;

	assign sched_ctl.shift_in = accept;
	assign sched_ctl.step     = (state_q == S_ROUND);
	assign round_ctl.load     = blk_done;
	assign round_ctl.step     = (state_q == S_ROUND);

	sha256_sched u_sched (
		.clk      (clk),
		.ctl      (sched_ctl),
		.msg_word (msg.message_word),
		.wt       (wt)
	);

	sha256_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (round_ctl),
		.init   (h_start),
		.wt     (wt),
		.kt     (k_word(cnt_q)),
		.vars   (vars)
	);

	// sequencer, chaining hash and digest output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			wcnt_q   <= '0;
			last_q   <= 1'b0;
			h_q      <= iv_hash();
			strobe_q <= 1'b0;
			result_q <= '0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						wcnt_q <= wcnt_q + 4'd1;
					end
					if (blk_done) begin
						h_q     <= h_start;
						last_q  <= msg.last_block;
						cnt_q   <= '0;
						state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(RoundCount - 1)) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					for (int i = 0; i < HashWords; i++) begin
						h_q[i] <= h_q[i] + vars[i];
					end
					cnt_q   <= '0;
					state_q <= last_q ? S_EMIT : S_IDLE;
				end
				S_EMIT: begin
					strobe_q              <= 1'b1;
					result_q.digest_word  <= h_q[cnt_q[2:0]];
					result_q.digest_index <= cnt_q[2:0];
					result_q.digest_last  <= (cnt_q[2:0] == 3'(HashWords - 1));
					cnt_q                 <= cnt_q + 6'd1;
					if (cnt_q[2:0] == 3'(HashWords - 1)) begin
						h_q     <= iv_hash();
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

	// checks
	a_strobe_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("digest word without preceding busy");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.digest_last) |-> (result.digest_index == 3'(HashWords - 1)))
		else $error("digest_last on wrong index");

	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROUND && cnt_q == 6'(RoundCount - 1)) |=> (state_q == S_ADD))
		else $error("round count overrun");

	a_wcnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> $stable(wcnt_q))
		else $error("word count moved while busy");

endmodule

### tb/sv/tb_sha256_block_compressor_core.sv
// ----------------------------------------------------------------------------
// SHA-256 block compressor core testbench
// Feeds message blocks word by word through the start/busy handshake,
// mirrors the compression in a local SHA-256 model and checks every digest
// word that comes out on the strobe against the oldest pending expectation.
// Two known digests are checked as typed values, the rest against the model.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sha256_block_compressor_core;
	import sha256_pkg::*;

	// standard initial hash and round constants
	localparam logic [31:0] InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam int DirectedWords = 48;
	localparam int RandomWords   = 362;
	localparam int DrainCycles   = 100;

	// directed blocks: a head word, fourteen fill words, a tail word
	typedef struct {
		logic [31:0]  head;
		logic [31:0]  fill;
		logic [31:0]  tail;
		logic         first;
		logic         last;
		logic         side_flags;
		logic         known;
		logic [255:0] digest;
	} block_row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	msg_t    msg = '0;
	logic    busy;
	logic    strobe;
	digest_t result;

	// local copy of the hashing state
	logic [31:0] chain_hash [8];
	logic [31:0] sched_win [16];
	logic [3:0]  word_pos;

	digest_t digest_q [$];
	int      mismatch_count = 0;
	int      sent_words = 0;
	int      idle_pct = 13;

	// "abc", the empty message (flags on inner words ignored), then all ones
	block_row_t directed_rows [3] = '{
		'{32'h61626380, 32'h00000000, 32'h00000018, 1'b1, 1'b1, 1'b1, 1'b1,
			256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad},
		'{32'h80000000, 32'h00000000, 32'h00000000, 1'b0, 1'b1, 1'b0, 1'b1,
			256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855},
		'{32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b0, 1'b0, 1'b1, 1'b0, 256'h0}
	};

	sha256_block_compressor_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.msg    (msg),
		.busy   (busy),
		.strobe (strobe),
		.result (result)
	);

	// 100 MHz clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [31:0] ror32(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] sched_sig0(logic [31:0] x);
		return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] sched_sig1(logic [31:0] x);
		return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] round_sig0(logic [31:0] x);
		return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
	endfunction

	function automatic logic [31:0] round_sig1(logic [31:0] x);
		return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
	endfunction

	// 64 rounds over the schedule window, then fold into the chaining hash
	function automatic void compress_block();
		logic [31:0] v [8];
		logic [31:0] wt;
		logic [31:0] t1;
		logic [31:0] t2;
		for (int i = 0; i < 8; i++) v[i] = chain_hash[i];
		for (int t = 0; t < 64; t++) begin
			if (t < 16) begin
				wt = sched_win[t];
			end else begin
				wt = sched_win[t % 16] + sched_sig0(sched_win[(t - 15) % 16])
					+ sched_win[(t - 7) % 16] + sched_sig1(sched_win[(t - 2) % 16]);
				sched_win[t % 16] = wt;
			end
			t1 = v[7] + round_sig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
				+ RoundK[t] + wt;
			t2 = round_sig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) chain_hash[i] = chain_hash[i] + v[i];
	endfunction

	// take one accepted word; flags only count on the sixteenth
	function automatic void absorb_word(msg_t m, ref digest_t produced [$]);
		sched_win[word_pos] = m.message_word;
		if (word_pos != 4'd15) begin
			word_pos = word_pos + 4'd1;
		end else begin
			word_pos = '0;
			if (m.first_block) begin
				for (int i = 0; i < 8; i++) chain_hash[i] = InitHash[i];
			end
			compress_block();
			if (m.last_block) begin
				for (int i = 0; i < 8; i++) begin
					produced.push_back('{digest_word: chain_hash[i],
						digest_index: 3'(i), digest_last: (i == 7)});
				end
				// digest out: next message starts from the initial hash
				for (int i = 0; i < 8; i++) chain_hash[i] = InitHash[i];
			end
		end
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
		mismatch_count++;
	endtask

	// drive one word, wait for it to be taken, queue what it produces
	task automatic send_word(msg_t m, logic [255:0] known, logic use_known);
		int gap;
		digest_t produced [$];
		gap = 0;
		while ($urandom_range(99) < idle_pct) gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		msg <= m;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent_words++;
		absorb_word(m, produced);
		if (use_known) begin
			foreach (produced[i]) produced[i].digest_word = known[255 - 32*i -: 32];
		end
		foreach (produced[i]) digest_q.push_back(produced[i]);
	endtask

	// one block; inner words carry random or fixed noise on the flags
	task automatic send_block(logic [31:0] words [16], logic first, logic last,
			logic rand_flags, logic flag_level, logic [255:0] known, logic use_known);
		msg_t m;
		for (int i = 0; i < 16; i++) begin
			m.message_word = words[i];
			if (i == 15) begin
				m.first_block = first;
				m.last_block  = last;
			end else if (rand_flags) begin
				m.first_block = 1'($urandom_range(1));
				m.last_block  = 1'($urandom_range(1));
			end else begin
				m.first_block = flag_level;
				m.last_block  = flag_level;
			end
			send_word(m, known, use_known);
		end
	endtask

	// digest word checker
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (digest_q.size() == 0) begin
				report_mismatch("unexpected digest word", result.digest_word, 32'h0);
			end else begin
				if (result.digest_word !== digest_q[0].digest_word)
					report_mismatch("digest_word", result.digest_word, digest_q[0].digest_word);
				if (result.digest_index !== digest_q[0].digest_index)
					report_mismatch("digest_index", 32'(result.digest_index),
						32'(digest_q[0].digest_index));
				if (result.digest_last !== digest_q[0].digest_last)
					report_mismatch("digest_last", 32'(result.digest_last),
						32'(digest_q[0].digest_last));
				void'(digest_q.pop_front());
			end
		end
	end

	// stimulus
	initial begin
		logic [31:0] words [16];
		int          pick;
		int          done_rand;
		for (int i = 0; i < 8; i++) chain_hash[i] = InitHash[i];
		for (int i = 0; i < 16; i++) sched_win[i] = '0;
		word_pos = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed blocks
		foreach (directed_rows[r]) begin
			words[0] = directed_rows[r].head;
			for (int i = 1; i < 15; i++) words[i] = directed_rows[r].fill;
			words[15] = directed_rows[r].tail;
			send_block(words, directed_rows[r].first, directed_rows[r].last, 1'b0,
				directed_rows[r].side_flags, directed_rows[r].digest, directed_rows[r].known);
		end

		// random blocks, sender idling 13%, then 55%, then never
		while (sent_words < DirectedWords + RandomWords) begin
			done_rand = sent_words - DirectedWords;
			if (done_rand < RandomWords / 3)
				idle_pct = 13;
			else if (done_rand < 2 * RandomWords / 3)
				idle_pct = 55;
			else
				idle_pct = 0;
			for (int i = 0; i < 16; i++) begin
				pick = $urandom_range(9);
				case (pick)
					0: words[i] = 32'h00000000;
					1: words[i] = 32'hffffffff;
					2: words[i] = 32'h80000000;
					default: words[i] = $urandom;
				endcase
			end
			send_block(words, 1'($urandom_range(3) == 0), 1'($urandom_range(1)),
				1'b1, 1'b0, 256'h0, 1'b0);
		end
		start <= 1'b0;

		// drain
		while (digest_q.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb_sha256_block_compressor_core OK");
		end else begin
			$display("tb_sha256_block_compressor_core NOT OK");
		end
		$finish;
	end

	// watchdog
	initial begin
		#1_000_000;
		$display("tb_sha256_block_compressor_core NOT OK");
		$finish;
	end

endmodule
